/* design/hrf_pkg.sv */
// Shared types, constants and character tables for the HTTP request framer.
`timescale 1ns / 1ps

package hrf_pkg;

	// Default size of the receive buffer in bytes; one byte less than this is kept.
	localparam int BUFFER_BYTES_DEF = 2048;

	// Field widths of the result.
	localparam int VALUE_W      = 20;
	localparam int BODY_START_W = 11;

	// Largest length value, and the largest value that can still take another digit.
	localparam logic [VALUE_W-1:0] VALUE_MAX      = 20'hFFFFF;
	localparam logic [VALUE_W-1:0] VALUE_MAX_DIV10 = 20'd104857;

	// Lengths of the matched words.
	localparam int POST_LEN = 5;
	localparam int KEY_LEN  = 15;

	// Characters used by the matchers.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;

	// One incoming request byte.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} req_item_t;

	// Status reported after each byte.
	typedef struct packed {
		logic                    complete;
		logic                    is_post;
		logic [VALUE_W-1:0]      body_length_needed;
		logic [BODY_START_W-1:0] body_start;
		logic                    buffer_full;
	} res_item_t;

	// Progress of the Content-Length value parse.
	typedef enum logic [1:0] {
		LEN_KEY_SEARCH = 2'd0,
		LEN_SKIP_BLANK = 2'd1,
		LEN_DIGITS     = 2'd2,
		LEN_DONE       = 2'd3
	} len_phase_t;

	// Progress through the CR LF CR LF that ends the headers.
	typedef enum logic [1:0] {
		BL_NONE    = 2'd0,
		BL_CR      = 2'd1,
		BL_CRLF    = 2'd2,
		BL_CRLFCR  = 2'd3
	} blank_prog_t;

	// Characters of the method prefix "POST ".
	function automatic logic [7:0] post_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h50; // P
			3'd1:    c = 8'h4F; // O
			3'd2:    c = 8'h53; // S
			3'd3:    c = 8'h54; // T
			3'd4:    c = 8'h20; // space
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Characters of the header key, lower case: "content-length:".
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = 8'h63; // c
			4'd1:    c = 8'h6F; // o
			4'd2:    c = 8'h6E; // n
			4'd3:    c = 8'h74; // t
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h6E; // n
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h2D; // -
			4'd8:    c = 8'h6C; // l
			4'd9:    c = 8'h65; // e
			4'd10:   c = 8'h6E; // n
			4'd11:   c = 8'h67; // g
			4'd12:   c = 8'h74; // t
			4'd13:   c = 8'h68; // h
			4'd14:   c = 8'h3A; // :
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* design/http_request_framer.sv */
// Top level of the HTTP request framer: parser stage and result buffer.
`timescale 1ns / 1ps

// Takes one received request byte per transaction and returns one status
// transaction per byte: whether the request (body included) is complete,
// whether it starts with "POST ", the parsed Content-Length, the offset just
// after the blank line that ends the headers, and whether bytes were dropped
// because more than BUFFER_BYTES-1 arrived. Set first_byte on the first byte
// of each request to clear the parse state. The block accepts one byte every
// clock cycle while req_stall is low; a byte passes through one input register,
// and its result is then written into the result buffer, from which it is
// offered to the consumer. A two-entry result buffer keeps the input flowing
// while the consumer stalls, until the buffer is full.
module http_request_framer import hrf_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res
);

	logic      push_valid;
	logic      push_ready;
	res_item_t push_data;

	// Per-byte parser with its input register.
	hrf_parser #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	// Result buffer toward the consumer.
	hrf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

/* design/hrf_parser.sv */
// Input register and per-byte parse state of the HTTP request framer.
`timescale 1ns / 1ps

module hrf_parser import hrf_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      push_valid,
	input  logic      push_ready,
	output res_item_t push_data
);

	localparam int CW   = $clog2(BUFFER_BYTES);
	localparam int CMPW = (CW > VALUE_W) ? CW : VALUE_W;
	localparam logic [CW-1:0] KEEP_MAX = CW'(BUFFER_BYTES - 1);

	// Input stage.
	logic      valid_s1;
	req_item_t item_s1;
	logic      fire;

	// Parse state.
	logic [CW-1:0]      kept_q;
	blank_prog_t        blank_q;
	logic               hdr_done_q;
	logic [CW-1:0]      hdr_end_q;
	logic [2:0]         method_q;
	logic               post_q;
	logic [3:0]         key_q;
	len_phase_t         phase_q;
	logic [VALUE_W-1:0] value_q;
	logic               neg_q;
	logic               ovf_q;
	logic               fin_q;

	// Next parse state.
	logic [CW-1:0]      kept_n;
	blank_prog_t        blank_n;
	logic               hdr_done_n;
	logic [CW-1:0]      hdr_end_n;
	logic [2:0]         method_n;
	logic               post_n;
	logic [3:0]         key_n;
	len_phase_t         phase_n;
	logic [VALUE_W-1:0] value_n;
	logic               neg_n;
	logic               ovf_n;
	logic               fin_n;

	assign fire      = valid_s1 && push_ready;
	assign req_stall = valid_s1 && !push_ready;

	// Input register takes a new transaction whenever the stage is free to move.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall) begin
			item_s1 <= req;
		end
	end

	// Next state of all matchers for the byte in the input register.
	always_comb begin : next_state
		logic [7:0]  b;
		logic [7:0]  lb;
		logic        take;
		logic        is_digit;
		logic        is_blank;
		logic [23:0] v10;
		logic [VALUE_W-1:0] v_sat;
		logic [CW-1:0] body_cnt;
		logic        cond;

		b = item_s1.data_byte;

		// A first byte starts from the reset state.
		if (item_s1.first_byte) begin
			kept_n     = '0;
			blank_n    = BL_NONE;
			hdr_done_n = 1'b0;
			hdr_end_n  = '0;
			method_n   = '0;
			post_n     = 1'b0;
			key_n      = '0;
			phase_n    = LEN_KEY_SEARCH;
			value_n    = '0;
			neg_n      = 1'b0;
			ovf_n      = 1'b0;
			fin_n      = 1'b0;
		end else begin
			kept_n     = kept_q;
			blank_n    = blank_q;
			hdr_done_n = hdr_done_q;
			hdr_end_n  = hdr_end_q;
			method_n   = method_q;
			post_n     = post_q;
			key_n      = key_q;
			phase_n    = phase_q;
			value_n    = value_q;
			neg_n      = neg_q;
			ovf_n      = ovf_q;
			fin_n      = fin_q;
		end

		take     = kept_n < KEEP_MAX;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		is_blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
			(b == CH_VT) || (b == CH_FF) || (b == CH_CR);
		lb = ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ? (b + 8'd32) : b;

		// Decimal accumulate with saturation.
		v10 = ({4'b0, value_n} << 3) + ({4'b0, value_n} << 1) + 24'(b - CH_ZERO);
		v_sat = ((value_n > VALUE_MAX_DIV10) || (v10 > 24'(VALUE_MAX))) ?
			VALUE_MAX : v10[VALUE_W-1:0];

		if (take) begin
			// Method prefix, checked on the first five kept bytes.
			if ((kept_n < CW'(POST_LEN)) && (CW'(method_n) == kept_n) &&
					(b == post_char(kept_n[2:0]))) begin
				method_n = method_n + 3'd1;
				if (method_n == 3'(POST_LEN)) begin
					post_n = 1'b1;
				end
			end

			// Content-Length key search and value parse.
			unique case (phase_n)
				LEN_SKIP_BLANK: begin
					if (is_blank) begin
						phase_n = LEN_SKIP_BLANK;
					end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
						neg_n   = (b == CH_MINUS);
						phase_n = LEN_DIGITS;
					end else if (is_digit) begin
						value_n = v_sat;
						phase_n = LEN_DIGITS;
					end else begin
						phase_n = LEN_DONE;
					end
				end
				LEN_DIGITS: begin
					if (is_digit) begin
						value_n = v_sat;
					end else begin
						phase_n = LEN_DONE;
					end
				end
				LEN_KEY_SEARCH: begin
					if (!hdr_done_n) begin
						if ((key_n < 4'(KEY_LEN)) && (lb == key_char(key_n))) begin
							key_n = key_n + 4'd1;
						end else begin
							key_n = (lb == key_char(4'd0)) ? 4'd1 : 4'd0;
						end
						if (key_n >= 4'(KEY_LEN)) begin
							phase_n = LEN_SKIP_BLANK;
							key_n   = '0;
						end
					end
				end
				LEN_DONE: begin
					phase_n = LEN_DONE;
				end
			endcase

			kept_n = kept_n + CW'(1);

			// Blank line that ends the headers.
			if (!hdr_done_n) begin
				priority if ((blank_n == BL_CRLFCR) && (b == CH_LF)) begin
					hdr_done_n = 1'b1;
					hdr_end_n  = kept_n;
					blank_n    = BL_NONE;
				end else if (b == CH_CR) begin
					blank_n = (blank_n == BL_CRLF) ? BL_CRLFCR : BL_CR;
				end else if ((b == CH_LF) && (blank_n == BL_CR)) begin
					blank_n = BL_CRLF;
				end else begin
					blank_n = BL_NONE;
				end
			end
		end else begin
			ovf_n = 1'b1;
		end

		// Completion once the headers are in and, for a POST with a length key, the body has arrived.
		body_cnt = kept_n - hdr_end_n;
		cond = 1'b0;
		if (hdr_done_n) begin
			priority if (!post_n || (phase_n == LEN_KEY_SEARCH)) begin
				cond = 1'b1;
			end else if (neg_n && (value_n != '0)) begin
				cond = 1'b0;
			end else begin
				cond = CMPW'(body_cnt) >= CMPW'(value_n);
			end
		end
		fin_n = fin_n || cond;
	end

	// Result fields from the updated state.
	always_comb begin : result
		logic [31:0] hdr_ext;
		hdr_ext = 32'(hdr_end_n);
		push_valid                   = valid_s1;
		push_data.complete           = fin_n;
		push_data.is_post            = post_n;
		push_data.body_length_needed = value_n;
		push_data.body_start         = hdr_ext[BODY_START_W-1:0];
		push_data.buffer_full        = ovf_n;
	end

	// Parse state advances with each transaction that leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q     <= '0;
			blank_q    <= BL_NONE;
			hdr_done_q <= 1'b0;
			hdr_end_q  <= '0;
			method_q   <= '0;
			post_q     <= 1'b0;
			key_q      <= '0;
			phase_q    <= LEN_KEY_SEARCH;
			value_q    <= '0;
			neg_q      <= 1'b0;
			ovf_q      <= 1'b0;
			fin_q      <= 1'b0;
		end else if (fire) begin
			kept_q     <= kept_n;
			blank_q    <= blank_n;
			hdr_done_q <= hdr_done_n;
			hdr_end_q  <= hdr_end_n;
			method_q   <= method_n;
			post_q     <= post_n;
			key_q      <= key_n;
			phase_q    <= phase_n;
			value_q    <= value_n;
			neg_q      <= neg_n;
			ovf_q      <= ovf_n;
			fin_q      <= fin_n;
		end
	end

endmodule

/* design/hrf_out_fifo.sv */
// Two-entry result buffer that decouples the parser from a stalling consumer.
`timescale 1ns / 1ps

module hrf_out_fifo import hrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  res_item_t push_data,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res
);

	res_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign push       = push_valid && push_ready;
	assign res_valid  = (count_q != 2'd0);
	assign pop        = res_valid && !res_stall;
	assign res        = slot_q[rd_ptr_q];

	// Storage for buffered results.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* test/http_request_framer_checker.sv */
// Status predictor and scoreboard for the HTTP request framer testbench.
`timescale 1ns / 1ps

module http_request_framer_checker import hrf_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  req_item_t req,
	input  logic      res_valid,
	input  logic      res_stall,
	input  res_item_t res,
	output int        fail_count,
	output int        outstanding
);

	// Matched words, first character in the top byte.
	localparam logic [8*POST_LEN-1:0] POST_TEXT = "POST ";
	localparam logic [8*KEY_LEN-1:0]  KEY_TEXT  = "content-length:";

	// Predicted parse state of the current request.
	int unsigned        kept;
	blank_prog_t        blank_prog;
	logic               hdr_done;
	int unsigned        hdr_end;
	int unsigned        method_pos;
	logic               post_seen;
	int unsigned        key_pos;
	len_phase_t         len_phase;
	logic [VALUE_W-1:0] len_value;
	logic               len_neg;
	logic               dropped;
	logic               done_flag;

	// Status words still owed by the block, oldest first.
	res_item_t status_q[$];
	int        errs = 0;

	function automatic logic [7:0] length_key_byte(input int unsigned idx);
		return KEY_TEXT[8*(KEY_LEN-1-idx) +: 8];
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
			b == CH_FF || b == CH_CR;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	// A new request starts from a clean parse.
	task automatic clear_parse();
		kept       = 0;
		blank_prog = BL_NONE;
		hdr_done   = 1'b0;
		hdr_end    = 0;
		method_pos = 0;
		post_seen  = 1'b0;
		key_pos    = 0;
		len_phase  = LEN_KEY_SEARCH;
		len_value  = '0;
		len_neg    = 1'b0;
		dropped    = 1'b0;
		done_flag  = 1'b0;
	endtask

	// Decimal accumulate that sticks at the largest value once it would overflow.
	task automatic push_digit(input logic [7:0] b);
		int unsigned v;
		v = 32'(len_value) * 32'd10 + 32'(b - CH_ZERO);
		if (len_value > VALUE_MAX_DIV10 || v > 32'(VALUE_MAX))
			len_value = VALUE_MAX;
		else
			len_value = v[VALUE_W-1:0];
	endtask

	// One byte that fits in the buffer feeds every matcher.
	task automatic take_byte(input logic [7:0] b);
		int unsigned pos;
		logic [7:0]  lb;
		pos  = kept;
		kept = pos + 1;

		// Method prefix, only over the first five bytes and only while unbroken.
		if (pos < POST_LEN && method_pos == pos &&
				b == POST_TEXT[8*(POST_LEN-1-pos) +: 8]) begin
			method_pos = pos + 1;
			if (method_pos == POST_LEN)
				post_seen = 1'b1;
		end

		// Length key search and value parse; the value parse runs into the body.
		case (len_phase)
			LEN_SKIP_BLANK: begin
				if (!is_blank(b)) begin
					if (b == CH_PLUS || b == CH_MINUS) begin
						len_neg   = (b == CH_MINUS);
						len_phase = LEN_DIGITS;
					end else if (is_digit(b)) begin
						push_digit(b);
						len_phase = LEN_DIGITS;
					end else begin
						len_phase = LEN_DONE;
					end
				end
			end
			LEN_DIGITS: begin
				if (is_digit(b))
					push_digit(b);
				else
					len_phase = LEN_DONE;
			end
			LEN_KEY_SEARCH: begin
				if (!hdr_done) begin
					lb = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + 8'd32 : b;
					if (key_pos < KEY_LEN && lb == length_key_byte(key_pos))
						key_pos = key_pos + 1;
					else
						key_pos = (lb == length_key_byte(0)) ? 1 : 0;
					if (key_pos >= KEY_LEN) begin
						len_phase = LEN_SKIP_BLANK;
						key_pos   = 0;
					end
				end
			end
			default: begin
			end
		endcase

		// Blank line that closes the headers.
		if (!hdr_done) begin
			if (blank_prog == BL_CRLFCR && b == CH_LF) begin
				hdr_done   = 1'b1;
				hdr_end    = kept;
				blank_prog = BL_NONE;
			end else if (b == CH_CR) begin
				blank_prog = (blank_prog == BL_CRLF) ? BL_CRLFCR : BL_CR;
			end else if (b == CH_LF && blank_prog == BL_CR) begin
				blank_prog = BL_CRLF;
			end else begin
				blank_prog = BL_NONE;
			end
		end
	endtask

	// Status the block should report after taking one byte.
	task automatic predict_status(input req_item_t item, output res_item_t st);
		logic reached;
		if (item.first_byte)
			clear_parse();
		if (kept < BUFFER_BYTES - 1)
			take_byte(item.data_byte);
		else
			dropped = 1'b1;

		reached = 1'b0;
		if (hdr_done) begin
			if (!post_seen || len_phase == LEN_KEY_SEARCH)
				reached = 1'b1;
			else if (len_neg && len_value != '0)
				reached = 1'b0;
			else
				reached = (kept - hdr_end) >= 32'(len_value);
		end
		done_flag = done_flag | reached;

		st.complete           = done_flag;
		st.is_post            = post_seen;
		st.body_length_needed = len_value;
		st.body_start         = hdr_end[BODY_START_W-1:0];
		st.buffer_full        = dropped;
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errs++;
			$display("time %0t: %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
		end
	endtask

	// Predict on every accepted byte and compare on every accepted status transaction.
	always @(posedge clk) begin : watch
		res_item_t st;
		if (!arst_n) begin
			clear_parse();
			status_q.delete();
		end else begin
			if (req_valid && !req_stall) begin
				predict_status(req, st);
				status_q.push_back(st);
			end
			if (res_valid && !res_stall) begin
				if (status_q.size() == 0) begin
					errs++;
					$display({"time %0t: status transaction with none expected, ",
						"expected none, actual %h"}, $time, res);
				end else begin
					st = status_q.pop_front();
					check_field("complete", st.complete, res.complete);
					check_field("is_post", st.is_post, res.is_post);
					check_field("body_length_needed", st.body_length_needed,
						res.body_length_needed);
					check_field("body_start", st.body_start, res.body_start);
					check_field("buffer_full", st.buffer_full, res.buffer_full);
				end
			end
		end
		fail_count  <= errs;
		outstanding <= status_q.size();
	end

endmodule

/* test/http_request_framer_tb.sv */
// Top of the HTTP request framer testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module http_request_framer_tb;
	import hrf_pkg::*;

	localparam int RANDOM_BYTES = 1800;
	localparam int OVERSIZE_LEN = BUFFER_BYTES_DEF - 1;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req       = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res;

	int fail_count;
	int outstanding;

	// Bytes of the request being built, and stimulus bookkeeping.
	logic [7:0]  msg_q[$];
	int unsigned random_sent = 0;
	int unsigned stall_left  = 0;
	int unsigned cycle_no    = 0;
	logic        quiet       = 1'b0;

	http_request_framer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	http_request_framer_checker status_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Every so often switch into or out of a stretch with no idling on either side.
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no % 256 == 0)
			quiet <= ($urandom_range(0, 3) == 0);
	end

	// Idle length: mostly none, often short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 94)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Status consumer stalls in runs.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			res_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			res_stall  <= 1'b0;
			stall_left <= idle_len();
		end
	end

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_q.push_back(s[i]);
	endtask

	task automatic add_eol();
		msg_q.push_back(CH_CR);
		msg_q.push_back(CH_LF);
	endtask

	// One byte transaction, with an optional gap in front of it.
	task automatic send_byte(input logic [7:0] b, input logic first);
		int unsigned gap;
		gap = idle_len();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= {b, first};
		do @(posedge clk); while (req_stall);
	endtask

	task automatic send_msg(input logic lead);
		foreach (msg_q[i])
			send_byte(msg_q[i], (i == 0) ? lead : 1'b0);
	endtask

	// Hold the input until every status transaction owed has come back.
	task automatic wait_for_all_status();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Key spelled right, in mixed case, or slightly wrong.
	task automatic add_length_key();
		int unsigned r;
		string       key_text;
		logic [7:0]  c;
		r = $urandom_range(0, 7);
		if (r == 0)
			add_text("Content-Length:");
		else if (r == 1)
			add_text("content-length:");
		else if (r == 2)
			add_text("CONTENT-LENGTH:");
		else if (r == 3)
			add_text("cContent-Length:");
		else if (r == 4)
			add_text("Content-Lenght:");
		else if (r == 5)
			add_text("Content-Length :");
		else begin
			key_text = "content-length:";
			for (int i = 0; i < key_text.len(); i++) begin
				c = key_text[i];
				if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1)
					c = c - 8'd32;
				msg_q.push_back(c);
			end
		end
	endtask

	// Length digits; body_len gets the value when it is small, else a small random body size.
	task automatic add_length_value(output int unsigned body_len);
		int unsigned r, v;
		r = $urandom_range(0, 9);
		body_len = $urandom_range(0, 8);
		if (r == 0) begin
			// No digits at all.
			return;
		end else if (r == 1) begin
			// Long values, most of which saturate.
			v = $urandom_range(100000, 99999999);
			add_text($sformatf("%0d", v));
		end else begin
			v = $urandom_range(0, 30);
			if (r == 2)
				add_text("00");
			add_text($sformatf("%0d", v));
			body_len = v;
		end
	endtask

	// A request line, a few headers, maybe a length, the blank line and a body.
	task automatic build_request();
		int unsigned r, want, body;
		logic        past;
		logic [7:0]  blanks[4];
		msg_q.delete();
		blanks = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};

		r = $urandom_range(0, 9);
		if (r <= 5)
			add_text("POST ");
		else if (r == 6)
			add_text("GET ");
		else if (r == 7)
			add_text("post ");
		else if (r == 8)
			add_text("POST");
		else
			add_text("POSTX ");
		add_text("/");
		repeat ($urandom_range(0, 4)) msg_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
		add_text(" HTTP/1.1");
		add_eol();
		repeat ($urandom_range(0, 2)) begin
			add_text("Host: h");
			add_eol();
		end

		want = $urandom_range(0, 6);
		past = 1'b0;
		if ($urandom_range(0, 3) != 0) begin
			add_length_key();
			// Sometimes the blank line falls between the key and the value.
			past = ($urandom_range(0, 11) == 0);
			repeat ($urandom_range(0, 2)) msg_q.push_back(blanks[$urandom_range(0, 3)]);
			if (past) begin
				add_eol();
				add_eol();
			end
			r = $urandom_range(0, 9);
			if (r == 8)
				msg_q.push_back(CH_PLUS);
			else if (r == 9)
				msg_q.push_back(CH_MINUS);
			add_length_value(want);
			if (!past) begin
				add_eol();
				if ($urandom_range(0, 3) == 0) begin
					add_text("Accept: */*");
					add_eol();
				end
			end
		end
		if (!past)
			add_eol();

		// Body a little short of, at, or past the length.
		body = want + $urandom_range(0, 3);
		if (body >= 2 && $urandom_range(0, 2) == 0)
			body = body - 2;
		if ($urandom_range(0, 7) == 0)
			add_text("Content-Length: 3");
		repeat (body) begin
			if ($urandom_range(0, 3) == 0)
				msg_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			else
				msg_q.push_back(8'($urandom_range(0, 255)));
		end

		// Now and then the request is cut short by the next one.
		if ($urandom_range(0, 9) == 0) begin
			r = $urandom_range(1, msg_q.size());
			while (msg_q.size() > r)
				void'(msg_q.pop_back());
		end
	endtask

	task automatic build_noise();
		msg_q.delete();
		repeat ($urandom_range(1, 24)) msg_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// A POST whose blank line ends on the last kept byte, followed by dropped bytes.
	task automatic build_oversized();
		msg_q.delete();
		add_text("POST / HTTP/1.1");
		add_eol();
		add_text("Content-Length: 3000");
		add_eol();
		add_text("X: ");
		while (msg_q.size() < OVERSIZE_LEN - 4)
			msg_q.push_back(8'h61);
		add_eol();
		add_eol();
		repeat (20) msg_q.push_back(8'($urandom_range(0, 255)));
	endtask

	initial begin : stimulus
		logic oversized_done;
		oversized_done = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero and all-ones bytes in a request that is not a POST.
		msg_q.delete();
		msg_q.push_back(8'h00);
		msg_q.push_back(8'hFF);
		add_eol();
		add_eol();
		send_msg(1'b1);

		// Directed: upper-case key, sign with no digits, complete at the blank line.
		msg_q.delete();
		add_text("POST CONTENT-LENGTH:-");
		add_eol();
		add_eol();
		send_msg(1'b1);
		wait_for_all_status();

		// Random traffic: mostly well-formed requests, some noise.
		while (random_sent < RANDOM_BYTES) begin
			if (!oversized_done && random_sent > RANDOM_BYTES / 2) begin
				wait_for_all_status();
				build_oversized();
				send_msg(1'b1);
				random_sent += msg_q.size();
				oversized_done = 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				build_noise();
				send_msg(1'($urandom_range(0, 1)));
				random_sent += msg_q.size();
			end else begin
				build_request();
				send_msg(1'b1);
				random_sent += msg_q.size();
			end
		end

		// Drain, then give anything extra a chance to show up.
		wait_for_all_status();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
design/hrf_pkg.sv
design/hrf_parser.sv
design/hrf_out_fifo.sv
design/http_request_framer.sv
test/http_request_framer_checker.sv
test/http_request_framer_tb.sv
